// File: rtl/core/wavhc_pkg.sv
// Package for the WAV header checker and rate rewriter.
// Holds header positions, tags, status and mode codes, and the shared structs.
// No dependencies.
package wavhc_pkg;

  localparam int unsigned PROD_W = 48;

  localparam logic [5:0] HDR_BYTES     = 6'd44;
  localparam logic [5:0] POS_RIFF_TAG  = 6'd3;
  localparam logic [5:0] POS_RIFF_SIZE = 6'd7;
  localparam logic [5:0] POS_WAVE_TAG  = 6'd11;
  localparam logic [5:0] POS_FMT_TAG   = 6'd15;
  localparam logic [5:0] POS_FMT_SIZE  = 6'd19;
  localparam logic [5:0] POS_TYPE      = 6'd21;
  localparam logic [5:0] POS_CHANNELS  = 6'd23;
  localparam logic [5:0] POS_RATE_LO   = 6'd24;
  localparam logic [5:0] POS_SRATE     = 6'd27;
  localparam logic [5:0] POS_BRATE     = 6'd31;
  localparam logic [5:0] POS_ALIGN     = 6'd33;
  localparam logic [5:0] POS_BITS      = 6'd35;
  localparam logic [5:0] POS_DATA_TAG  = 6'd39;
  localparam logic [5:0] POS_DATA_SIZE = 6'd43;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_SIZE = 32'd16;
  localparam logic [32:0] RIFF_BASE = 33'd36;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  localparam logic [15:0] PCM_TYPE   = 16'd1;
  localparam logic [15:0] ONE_CHAN   = 16'd1;
  localparam logic [15:0] TWO_CHAN   = 16'd2;
  localparam logic [15:0] BITS_8     = 16'd8;
  localparam logic [15:0] BITS_16    = 16'd16;

  localparam logic [1:0] MODE_CHECK  = 2'd0;
  localparam logic [1:0] MODE_HALF   = 2'd1;
  localparam logic [1:0] MODE_DOUBLE = 2'd2;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_RIFF      = 4'd1;
  localparam logic [3:0] ST_WAVE      = 4'd2;
  localparam logic [3:0] ST_FMT       = 4'd3;
  localparam logic [3:0] ST_FMT_SIZE  = 4'd4;
  localparam logic [3:0] ST_TYPE      = 4'd5;
  localparam logic [3:0] ST_CHANNELS  = 4'd6;
  localparam logic [3:0] ST_BYTE_RATE = 4'd7;
  localparam logic [3:0] ST_BITS      = 4'd8;
  localparam logic [3:0] ST_ALIGN     = 4'd9;
  localparam logic [3:0] ST_DATA_TAG  = 4'd10;
  localparam logic [3:0] ST_SHORT     = 4'd11;
  localparam logic [3:0] ST_BAD_SIZE  = 4'd12;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [3:0] status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic             load;
    logic [2:0]       cnt;
    result_t [3:0]    res;
  } burst_t;

  typedef struct packed {
    logic              valid;
    logic [7:0]        data;
    logic              eof;
    logic [PROD_W-1:0] prod;
  } stage_t;

endpackage

// File: rtl/core/wavhc_if.sv
// Request and result channel interfaces of the WAV header checker.
// Depends on nothing; payload widths follow the block's fields.
interface wavhc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_file;

  modport source (output valid, output in_byte, output end_of_file, input ready);
  modport sink (input valid, input in_byte, input end_of_file, output ready);
endinterface

interface wavhc_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] out_byte;
  logic [3:0] status;
  logic       last_of_run;

  modport source (output valid, output result_kind, output out_byte, output status,
                  output last_of_run, input ready);
  modport sink (input valid, input result_kind, input out_byte, input status,
                input last_of_run, output ready);
endinterface

// File: rtl/core/wavhc_front.sv
// Input register stage: holds one request and the registered rate product.
// Depends on wavhc_pkg and wavhc_in_if.
module wavhc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  wavhc_in_if.sink             in_chan,
  input  logic [31:0]          sample_rate,
  input  logic                 take,
  output wavhc_pkg::stage_t    stage
);

  logic                          valid_r;
  logic                          eof_r;
  logic [7:0]                    byte_r;
  logic [7:0]                    prev_r;
  logic [wavhc_pkg::PROD_W-1:0]  prod_r;
  logic [wavhc_pkg::PROD_W-1:0]  prod_nxt;
  logic                          accept;

  assign in_chan.ready = !valid_r || take;
  assign accept = in_chan.valid && in_chan.ready;
  assign prod_nxt = wavhc_pkg::PROD_W'(sample_rate)
                  * wavhc_pkg::PROD_W'({in_chan.in_byte, prev_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_chan.in_byte;
      eof_r  <= in_chan.end_of_file;
      prod_r <= prod_nxt;
      if (!in_chan.end_of_file) begin
        prev_r <= in_chan.in_byte;
      end
    end
  end

  assign stage.valid = valid_r;
  assign stage.data  = byte_r;
  assign stage.eof   = eof_r;
  assign stage.prod  = prod_r;

endmodule

// File: rtl/core/wavhc_parse.sv
// Header parser and stream state: checks fields, rewrites rates, builds result bursts.
// Depends on wavhc_pkg.
module wavhc_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wavhc_pkg::stage_t    stage,
  input  logic [1:0]           speed_mode,
  input  logic                 burst_free,
  output logic                 take,
  output logic [31:0]          sample_rate,
  output wavhc_pkg::burst_t    burst
);

  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] riff_r, riff_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] srate_r, srate_nxt;
  logic [31:0] brate_r, brate_nxt;
  logic [15:0] align_r, align_nxt;
  logic [31:0] dsize_r, dsize_nxt;
  logic [31:0] dcount_r, dcount_nxt;
  logic        err_r, err_nxt;

  logic        echo;
  logic [31:0] acc_shift;
  logic [15:0] half;
  logic [31:0] rate_word;
  logic [16:0] align_want;
  logic [32:0] riff_want;
  logic [3:0]  hdr_st;
  logic [3:0]  eof_st;
  logic [2:0]  cnt;
  wavhc_pkg::result_t [3:0] res;

  assign echo = (speed_mode == wavhc_pkg::MODE_HALF) || (speed_mode == wavhc_pkg::MODE_DOUBLE);
  assign acc_shift = {stage.data, acc_r[31:8]};
  assign half = acc_shift[31:16];
  assign rate_word = (speed_mode == wavhc_pkg::MODE_HALF) ? {1'b0, acc_shift[31:1]}
                                                          : {acc_shift[30:0], 1'b0};
  assign align_want = (half == wavhc_pkg::BITS_16) ? {chan_r, 1'b0} : {1'b0, chan_r};
  assign riff_want = wavhc_pkg::RIFF_BASE + {1'b0, dcount_r};

  always_comb begin
    priority if (pos_r < wavhc_pkg::HDR_BYTES) begin
      eof_st = wavhc_pkg::ST_SHORT;
    end else if (dcount_r < dsize_r) begin
      eof_st = wavhc_pkg::ST_SHORT;
    end else if ((dcount_r > dsize_r) && ({1'b0, riff_r} != riff_want)) begin
      eof_st = wavhc_pkg::ST_BAD_SIZE;
    end else begin
      eof_st = wavhc_pkg::ST_OK;
    end
  end

  always_comb begin
    hdr_st = wavhc_pkg::ST_OK;
    unique case (pos_r)
      wavhc_pkg::POS_RIFF_TAG:
        if (acc_shift != wavhc_pkg::TAG_RIFF) hdr_st = wavhc_pkg::ST_RIFF;
      wavhc_pkg::POS_WAVE_TAG:
        if (acc_shift != wavhc_pkg::TAG_WAVE) hdr_st = wavhc_pkg::ST_WAVE;
      wavhc_pkg::POS_FMT_TAG:
        if (acc_shift != wavhc_pkg::TAG_FMT) hdr_st = wavhc_pkg::ST_FMT;
      wavhc_pkg::POS_FMT_SIZE:
        if (acc_shift != wavhc_pkg::FMT_SIZE) hdr_st = wavhc_pkg::ST_FMT_SIZE;
      wavhc_pkg::POS_TYPE:
        if (half != wavhc_pkg::PCM_TYPE) hdr_st = wavhc_pkg::ST_TYPE;
      wavhc_pkg::POS_CHANNELS:
        if (half != wavhc_pkg::ONE_CHAN && half != wavhc_pkg::TWO_CHAN) begin
          hdr_st = wavhc_pkg::ST_CHANNELS;
        end
      wavhc_pkg::POS_ALIGN:
        if (stage.prod != {16'd0, brate_r}) hdr_st = wavhc_pkg::ST_BYTE_RATE;
      wavhc_pkg::POS_BITS:
        if (half != wavhc_pkg::BITS_8 && half != wavhc_pkg::BITS_16) begin
          hdr_st = wavhc_pkg::ST_BITS;
        end else if ({1'b0, align_r} != align_want) begin
          hdr_st = wavhc_pkg::ST_ALIGN;
        end
      wavhc_pkg::POS_DATA_TAG:
        if (acc_shift != wavhc_pkg::TAG_DATA) hdr_st = wavhc_pkg::ST_DATA_TAG;
      default: hdr_st = wavhc_pkg::ST_OK;
    endcase
  end

  always_comb begin
    pos_nxt    = pos_r;
    acc_nxt    = acc_r;
    riff_nxt   = riff_r;
    chan_nxt   = chan_r;
    srate_nxt  = srate_r;
    brate_nxt  = brate_r;
    align_nxt  = align_r;
    dsize_nxt  = dsize_r;
    dcount_nxt = dcount_r;
    err_nxt    = err_r;
    res        = '0;
    cnt        = 3'd0;

    if (stage.eof) begin
      if (!err_r) begin
        res[0].kind   = wavhc_pkg::KIND_STATUS;
        res[0].status = eof_st;
        cnt = 3'd1;
      end
      pos_nxt    = '0;
      acc_nxt    = '0;
      riff_nxt   = '0;
      chan_nxt   = '0;
      srate_nxt  = '0;
      brate_nxt  = '0;
      align_nxt  = '0;
      dsize_nxt  = '0;
      dcount_nxt = '0;
      err_nxt    = 1'b0;
    end else if (!err_r) begin
      if (pos_r < wavhc_pkg::HDR_BYTES) begin
        acc_nxt = acc_shift;
        pos_nxt = pos_r + 6'd1;
        if (pos_r == wavhc_pkg::POS_RIFF_SIZE) riff_nxt = acc_shift;
        if (pos_r == wavhc_pkg::POS_CHANNELS) chan_nxt = half;
        if (pos_r == wavhc_pkg::POS_SRATE) srate_nxt = acc_shift;
        if (pos_r == wavhc_pkg::POS_BRATE) brate_nxt = acc_shift;
        if (pos_r == wavhc_pkg::POS_ALIGN) align_nxt = half;
        if (pos_r == wavhc_pkg::POS_DATA_SIZE) dsize_nxt = acc_shift;
        if (echo) begin
          if (pos_r < wavhc_pkg::POS_RATE_LO || pos_r > wavhc_pkg::POS_BRATE) begin
            res[0].kind = wavhc_pkg::KIND_BYTE;
            res[0].data = stage.data;
            cnt = 3'd1;
          end else if (pos_r == wavhc_pkg::POS_SRATE || pos_r == wavhc_pkg::POS_BRATE) begin
            for (int i = 0; i < 4; i++) begin
              res[i].kind = wavhc_pkg::KIND_BYTE;
              res[i].data = rate_word[8*i +: 8];
            end
            cnt = 3'd4;
          end
        end
        if (hdr_st != wavhc_pkg::ST_OK) begin
          res[cnt[1:0]].kind   = wavhc_pkg::KIND_STATUS;
          res[cnt[1:0]].data   = '0;
          res[cnt[1:0]].status = hdr_st;
          cnt = cnt + 3'd1;
          err_nxt = 1'b1;
        end
      end else begin
        if (echo) begin
          res[0].kind = wavhc_pkg::KIND_BYTE;
          res[0].data = stage.data;
          cnt = 3'd1;
        end
        if (dcount_r != wavhc_pkg::COUNT_MAX) dcount_nxt = dcount_r + 32'd1;
      end
    end

    for (int i = 0; i < 4; i++) begin
      res[i].last = (cnt == 3'(i + 1));
    end
  end

  assign take = stage.valid && ((cnt == 3'd0) || burst_free);
  assign sample_rate = srate_r;
  assign burst.load = take && (cnt != 3'd0);
  assign burst.cnt  = cnt;
  assign burst.res  = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      acc_r    <= '0;
      riff_r   <= '0;
      chan_r   <= '0;
      srate_r  <= '0;
      brate_r  <= '0;
      align_r  <= '0;
      dsize_r  <= '0;
      dcount_r <= '0;
      err_r    <= 1'b0;
    end else if (take) begin
      pos_r    <= pos_nxt;
      acc_r    <= acc_nxt;
      riff_r   <= riff_nxt;
      chan_r   <= chan_nxt;
      srate_r  <= srate_nxt;
      brate_r  <= brate_nxt;
      align_r  <= align_nxt;
      dsize_r  <= dsize_nxt;
      dcount_r <= dcount_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

// File: rtl/core/wavhc_burst.sv
// Result buffer: holds the up to four results of one request and drives them out in order.
// Depends on wavhc_pkg and wavhc_out_if.
module wavhc_burst (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wavhc_pkg::burst_t    burst,
  output logic                 free,
  wavhc_out_if.source          out_chan
);

  wavhc_pkg::result_t [3:0] buf_r;
  logic [2:0]               rem_r;
  logic [1:0]               idx_r;
  logic                     pop;

  assign out_chan.valid       = (rem_r != 3'd0);
  assign out_chan.result_kind = buf_r[idx_r].kind;
  assign out_chan.out_byte    = buf_r[idx_r].data;
  assign out_chan.status      = buf_r[idx_r].status;
  assign out_chan.last_of_run = buf_r[idx_r].last;

  assign pop  = out_chan.valid && out_chan.ready;
  assign free = (rem_r == 3'd0) || ((rem_r == 3'd1) && out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
      idx_r <= 2'd0;
    end else if (burst.load) begin
      rem_r <= burst.cnt;
      idx_r <= 2'd0;
    end else if (pop) begin
      rem_r <= rem_r - 3'd1;
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (burst.load) begin
      buf_r <= burst.res;
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'd4)
    else $error("result buffer count out of range");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    burst.load |-> (rem_r == 3'd0) || ((rem_r == 3'd1) && out_chan.ready))
    else $error("burst loaded over pending results");

  a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.last_of_run == (rem_r == 3'd1)))
    else $error("last flag does not match end of burst");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (rem_r == 3'd0))
    else $error("result buffer not empty after reset");

endmodule

// File: rtl/core/wav_header_check_and_rate_rewrite_top.sv
// Top level of the WAV header checker and rate rewriter.
// Depends on wavhc_pkg, wavhc_if, wavhc_front, wavhc_parse and wavhc_burst.
//
//  Port       Dir  Payload                                       Handshake
//  in_chan    in   in_byte[7:0], end_of_file                     valid/ready
//  out_chan   out  result_kind, out_byte[7:0], status[3:0],      valid/ready
//                  last_of_run
//  cfg_*      in   cfg_wdata[1:0] (speed mode)                   cfg_we, no wait
//
// A request is held in the input register, then its results go to the result buffer;
// one request per cycle holds while out_chan is ready and each has at most one result.
// A rewritten rate field produces four results, driven out in order from the buffer.
// Reset is synchronous and clears the stream state and speed mode to zero.
// A stalled output holds the buffer; the input register still takes one more request.
module wav_header_check_and_rate_rewrite_top (
  input  logic        clk,
  input  logic        rst_n,
  wavhc_in_if.sink    in_chan,
  wavhc_out_if.source out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  logic [1:0]         speed_mode_r;
  logic               take;
  logic               burst_free;
  logic [31:0]        sample_rate;
  wavhc_pkg::stage_t  stage;
  wavhc_pkg::burst_t  burst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_mode_r <= wavhc_pkg::MODE_CHECK;
    end else if (cfg_we) begin
      speed_mode_r <= cfg_wdata;
    end
  end

  wavhc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .sample_rate (sample_rate),
    .take        (take),
    .stage       (stage)
  );

  wavhc_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage       (stage),
    .speed_mode  (speed_mode_r),
    .burst_free  (burst_free),
    .take        (take),
    .sample_rate (sample_rate),
    .burst       (burst)
  );

  wavhc_burst u_burst (
    .clk      (clk),
    .rst_n    (rst_n),
    .burst    (burst),
    .free     (burst_free),
    .out_chan (out_chan)
  );

endmodule

// File: tb/tb.sv
// Self-checking testbench for wav_header_check_and_rate_rewrite_top.
// Walks a short directed table and then sends random WAV streams under four speed modes and idle mixes.
// Depends on wavhc_pkg, wavhc_if and the RTL of the top level.
module tb;
  import wavhc_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int PHASE_REQUESTS = 36;
  localparam int DIR_ROWS = 25;

  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_STATUS} row_check_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;
    logic       eof;
    row_check_t chk;
    logic [3:0] st;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_wdata;

  wavhc_in_if req_ch ();
  wavhc_out_if res_ch ();

  wav_header_check_and_rate_rewrite_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_ch),
    .out_chan (res_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state, one copy of the stream state and the speed mode.
  logic [1:0]  speed;
  logic [5:0]  hdr_pos;
  logic [31:0] acc;
  logic [31:0] riff_sz;
  logic [15:0] chans;
  logic [31:0] srate;
  logic [31:0] brate;
  logic [15:0] balign;
  logic [31:0] data_sz;
  logic [31:0] data_cnt;
  logic        err_seen;

  result_t step_out[$];
  result_t pending_results[$];
  result_t res_want;
  logic [7:0] wav_hdr [44];
  dir_row_t dir_rows [DIR_ROWS];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int results_checked = 0;
  int total_requests = 0;
  int live_requests = 0;
  int cycle_count = 0;
  logic [15:0] status_seen = '0;

  function automatic void clear_stream();
    hdr_pos = '0;
    acc = '0;
    riff_sz = '0;
    chans = '0;
    srate = '0;
    brate = '0;
    balign = '0;
    data_sz = '0;
    data_cnt = '0;
    err_seen = 1'b0;
  endfunction

  function automatic void put_le(int unsigned pos, logic [31:0] val, int unsigned nbytes);
    for (int i = 0; i < nbytes; i++) wav_hdr[pos + i] = val[8*i +: 8];
  endfunction

  // Works out the results of one request; last_of_run is set when they are queued.
  task automatic predict_rewrite(input logic [7:0] b, input logic eof, output bit ignored);
    logic [5:0]  pos;
    logic [3:0]  st;
    logic [15:0] half;
    logic [63:0] prod;
    logic [31:0] word;
    logic        echo;
    ignored = 1'b0;
    step_out.delete();
    echo = (speed == MODE_HALF) || (speed == MODE_DOUBLE);
    st = ST_OK;
    if (eof) begin
      if (!err_seen) begin
        if (hdr_pos < HDR_BYTES) st = ST_SHORT;
        else if (data_cnt < data_sz) st = ST_SHORT;
        else if (data_cnt > data_sz && {1'b0, riff_sz} != RIFF_BASE + {1'b0, data_cnt})
          st = ST_BAD_SIZE;
        step_out.push_back({KIND_STATUS, 8'h00, st, 1'b0});
      end
      clear_stream();
    end else if (err_seen) begin
      ignored = 1'b1;
    end else if (hdr_pos < HDR_BYTES) begin
      pos = hdr_pos;
      acc = {b, acc[31:8]};
      half = acc[31:16];
      case (pos)
        POS_RIFF_TAG: if (acc != TAG_RIFF) st = ST_RIFF;
        POS_RIFF_SIZE: riff_sz = acc;
        POS_WAVE_TAG: if (acc != TAG_WAVE) st = ST_WAVE;
        POS_FMT_TAG: if (acc != TAG_FMT) st = ST_FMT;
        POS_FMT_SIZE: if (acc != FMT_SIZE) st = ST_FMT_SIZE;
        POS_TYPE: if (half != PCM_TYPE) st = ST_TYPE;
        POS_CHANNELS: begin
          chans = half;
          if (half != ONE_CHAN && half != TWO_CHAN) st = ST_CHANNELS;
        end
        POS_SRATE: srate = acc;
        POS_BRATE: brate = acc;
        POS_ALIGN: begin
          balign = half;
          prod = 64'(srate) * 64'(half);
          if (prod != 64'(brate)) st = ST_BYTE_RATE;
        end
        POS_BITS: begin
          if (half != BITS_8 && half != BITS_16) st = ST_BITS;
          else if (balign != (half / 16'd8) * chans) st = ST_ALIGN;
        end
        POS_DATA_TAG: if (acc != TAG_DATA) st = ST_DATA_TAG;
        POS_DATA_SIZE: data_sz = acc;
        default: ;
      endcase
      if (echo) begin
        if (pos < POS_RATE_LO || pos > POS_BRATE) begin
          step_out.push_back({KIND_BYTE, b, ST_OK, 1'b0});
        end else if (pos == POS_SRATE || pos == POS_BRATE) begin
          word = (pos == POS_SRATE) ? srate : brate;
          word = (speed == MODE_HALF) ? (word >> 1) : (word << 1);
          for (int i = 0; i < 4; i++) step_out.push_back({KIND_BYTE, word[8*i +: 8], ST_OK, 1'b0});
        end
      end
      if (st != ST_OK) begin
        step_out.push_back({KIND_STATUS, 8'h00, st, 1'b0});
        err_seen = 1'b1;
      end
      hdr_pos = pos + 6'd1;
    end else begin
      if (echo) step_out.push_back({KIND_BYTE, b, ST_OK, 1'b0});
      if (data_cnt != COUNT_MAX) data_cnt = data_cnt + 32'd1;
    end
  endtask

  // Entered and left at a falling edge.
  task automatic send_item(input logic [7:0] b, input logic eof, input row_check_t chk,
                           input logic [3:0] st);
    result_t r;
    bit ignored;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.in_byte <= b;
    req_ch.end_of_file <= eof;
    do @(posedge clk); while (!req_ch.ready);
    predict_rewrite(b, eof, ignored);
    total_requests++;
    if (!ignored) live_requests++;
    case (chk)
      CHK_PRED: begin
        for (int i = 0; i < step_out.size(); i++) begin
          r = step_out[i];
          r.last = (i == step_out.size() - 1);
          pending_results.push_back(r);
        end
      end
      CHK_STATUS: pending_results.push_back({KIND_STATUS, 8'h00, st, 1'b1});
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Waits until the block is idle, then writes the speed mode.
  task automatic set_speed(input logic [1:0] m);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    speed = m;
  endtask

  task automatic send_wav_file();
    int unsigned style, ch, bits, align, dsize, nhdr, flaw_lo, flaw_hi, n;
    int dcount;
    logic [31:0] rate, riff;
    style = $urandom_range(0, 99);
    if (style >= 90) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
        send_item((i < 4 && $urandom_range(0, 1)) ? TAG_RIFF[8*i +: 8] : 8'($urandom),
                  1'b0, CHK_PRED, ST_OK);
      send_item(8'($urandom), 1'b1, CHK_PRED, ST_OK);
      return;
    end
    ch = $urandom_range(1, 2);
    bits = $urandom_range(0, 1) ? 16 : 8;
    align = bits / 8 * ch;
    case ($urandom_range(0, 7))
      0: rate = 32'hFFFF_FFFF;
      1: rate = 32'h8000_0000;
      2: rate = 32'h0;
      3: rate = 32'h1;
      4, 5: rate = $urandom_range(8000, 96000);
      default: rate = $urandom;
    endcase
    dsize = $urandom_range(0, 5);
    dcount = int'(dsize) + int'($urandom_range(0, 4)) - 2;
    if (dcount < 0) dcount = 0;
    case ($urandom_range(0, 3))
      0, 1: riff = 32'(36 + dcount);
      2: riff = 32'(36 + dsize);
      default: riff = $urandom;
    endcase
    put_le(0, TAG_RIFF, 4);
    put_le(4, riff, 4);
    put_le(8, TAG_WAVE, 4);
    put_le(12, TAG_FMT, 4);
    put_le(16, FMT_SIZE, 4);
    put_le(20, 32'(PCM_TYPE), 2);
    put_le(22, ch, 2);
    put_le(24, rate, 4);
    put_le(28, 32'(rate * align), 4);
    put_le(32, align, 2);
    put_le(34, bits, 2);
    put_le(36, TAG_DATA, 4);
    put_le(40, dsize, 4);
    if (style >= 60 && style < 80) begin
      flaw_lo = 0;
      flaw_hi = 0;
      case ($urandom_range(0, 9))
        0: flaw_hi = 3;
        1: begin flaw_lo = 8; flaw_hi = 11; end
        2: begin flaw_lo = 12; flaw_hi = 15; end
        3: begin flaw_lo = 16; flaw_hi = 19; end
        4: begin flaw_lo = 20; flaw_hi = 21; end
        5: put_le(22, $urandom_range(0, 1) ? 32'd0 : 32'd3, 2);
        6: begin flaw_lo = 28; flaw_hi = 31; end
        7: put_le(34, $urandom_range(0, 1) ? 32'd24 : 32'($urandom_range(0, 65535)), 2);
        8: begin
          rate = $urandom_range(1, 200000);
          align = align + $urandom_range(1, 3);
          put_le(24, rate, 4);
          put_le(28, 32'(rate * align), 4);
          put_le(32, align, 2);
        end
        default: begin flaw_lo = 36; flaw_hi = 39; end
      endcase
      if (flaw_hi != 0) wav_hdr[$urandom_range(flaw_lo, flaw_hi)] ^= 8'($urandom_range(1, 255));
    end
    nhdr = (style >= 80) ? $urandom_range(0, 43) : 44;
    for (int i = 0; i < nhdr; i++) send_item(wav_hdr[i], 1'b0, CHK_PRED, ST_OK);
    if (nhdr == 44)
      for (int i = 0; i < dcount; i++) send_item(8'($urandom), 1'b0, CHK_PRED, ST_OK);
    send_item(8'($urandom), 1'b1, CHK_PRED, ST_OK);
  endtask

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("unexpected result: kind %0d, byte %02h, status %0d", res_ch.result_kind,
               res_ch.out_byte, res_ch.status);
      end else begin
        res_want = pending_results.pop_front();
        results_checked++;
        if (res_ch.result_kind == KIND_STATUS) status_seen[res_ch.status] = 1'b1;
        if (res_ch.result_kind !== res_want.kind) begin
          mismatches++;
          $error("result_kind: expected %0d, got %0d", res_want.kind, res_ch.result_kind);
        end
        if (res_ch.out_byte !== res_want.data) begin
          mismatches++;
          $error("out_byte: expected %02h, got %02h", res_want.data, res_ch.out_byte);
        end
        if (res_ch.status !== res_want.status) begin
          mismatches++;
          $error("status: expected %0d, got %0d", res_want.status, res_ch.status);
        end
        if (res_ch.last_of_run !== res_want.last) begin
          mismatches++;
          $error("last_of_run: expected %0d, got %0d", res_want.last, res_ch.last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
               pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    dir_rows = '{
      '{MODE_CHECK, 8'h00, 1'b1, CHK_STATUS, ST_SHORT},
      '{MODE_CHECK, "R", 1'b0, CHK_NONE, ST_OK},
      '{MODE_CHECK, "I", 1'b0, CHK_NONE, ST_OK},
      '{MODE_CHECK, "F", 1'b0, CHK_NONE, ST_OK},
      '{MODE_CHECK, "X", 1'b0, CHK_STATUS, ST_RIFF},
      '{MODE_CHECK, 8'hFF, 1'b0, CHK_NONE, ST_OK},
      '{MODE_CHECK, 8'h00, 1'b0, CHK_NONE, ST_OK},
      '{MODE_CHECK, 8'hFF, 1'b1, CHK_NONE, ST_OK},
      '{MODE_CHECK, "R", 1'b0, CHK_NONE, ST_OK},
      '{MODE_CHECK, "I", 1'b0, CHK_NONE, ST_OK},
      '{MODE_CHECK, "F", 1'b0, CHK_NONE, ST_OK},
      '{MODE_CHECK, "F", 1'b0, CHK_NONE, ST_OK},
      '{MODE_CHECK, 8'hAA, 1'b1, CHK_STATUS, ST_SHORT},
      '{MODE_HALF, "R", 1'b0, CHK_PRED, ST_OK},
      '{MODE_HALF, "I", 1'b0, CHK_PRED, ST_OK},
      '{MODE_HALF, "F", 1'b0, CHK_PRED, ST_OK},
      '{MODE_HALF, 8'h00, 1'b0, CHK_PRED, ST_OK},
      '{MODE_HALF, 8'h55, 1'b1, CHK_PRED, ST_OK},
      '{MODE_DOUBLE, 8'hFF, 1'b0, CHK_PRED, ST_OK},
      '{MODE_DOUBLE, 8'h00, 1'b1, CHK_PRED, ST_OK},
      '{MODE_SPARE, "R", 1'b0, CHK_NONE, ST_OK},
      '{MODE_SPARE, "I", 1'b0, CHK_NONE, ST_OK},
      '{MODE_SPARE, "F", 1'b0, CHK_NONE, ST_OK},
      '{MODE_SPARE, "F", 1'b0, CHK_NONE, ST_OK},
      '{MODE_SPARE, 8'h00, 1'b1, CHK_STATUS, ST_SHORT}
    };
    speed = MODE_CHECK;
    clear_stream();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= MODE_CHECK;
    req_ch.valid <= 1'b0;
    req_ch.in_byte <= 8'h00;
    req_ch.end_of_file <= 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].mode != speed) set_speed(dir_rows[i].mode);
      send_item(dir_rows[i].data, dir_rows[i].eof, dir_rows[i].chk, dir_rows[i].st);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      int start;
      set_speed(2'(ph % 4));
      case ((ph + ph / 4) % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 69; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 69; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      start = total_requests;
      while (total_requests - start < PHASE_REQUESTS) send_wav_file();
    end

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d requests (%0d not skipped after an error) over speed modes 0 to 3.",
             total_requests, live_requests);
    $display("Checked %0d results; status codes seen, as a bit mask: %04h.", results_checked,
             status_seen);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/wavhc_pkg.sv
rtl/core/wavhc_if.sv
rtl/core/wavhc_front.sv
rtl/core/wavhc_parse.sv
rtl/core/wavhc_burst.sv
rtl/core/wav_header_check_and_rate_rewrite_top.sv
tb/tb.sv
